// ===== design/pbfi_pkg.sv =====
// Shared types and constants for the partitioned Bloom filter insert block.
// Used by the controller, the datapath, the top level, the checker and the testbench.
package pbfi_pkg;

  localparam int MAX_REPS_DEF = 4;
  localparam int MAX_BITS_DEF = 16384;

  localparam int HASH_W     = 64;
  localparam int PART_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NREP_W     = 3;
  localparam int NHASH_W    = 8;
  localparam int FLEN_W     = 15;
  localparam int REPIDX_W   = 2;
  localparam int BITIDX_W   = 14;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_REPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_LEN   = 2'd3;

  localparam logic [NREP_W-1:0]  NREP_RST  = 3'd1;
  localparam logic [NHASH_W-1:0] NHASH_RST = 8'd3;
  localparam logic [PART_W-1:0]  NPART_RST = 16'd1;
  localparam logic [FLEN_W-1:0]  FLEN_RST  = 15'd16384;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_RD_OUT,
    S_IB,
    S_IB_W,
    S_WA,
    S_WA_W,
    S_REP,
    S_REP_W,
    S_PL,
    S_PL_W,
    S_HASH,
    S_HASH_W,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DS_IB_P,
    DS_PROD_P,
    DS_WA_L,
    DS_NB_L,
    DS_PART_L
  } dsel_t;

  typedef struct packed {
    logic  init;
    logic  clear;
    logic  div_start;
    dsel_t dsel;
    logic  next_n;
    logic  next_rep;
    logic  emit_rd;
    logic  emit_ins;
  } ctl_cmd_t;

  typedef struct packed {
    logic reps_zero;
    logic p_zero;
    logic len_zero;
    logic hashes_zero;
    logic rep_last;
    logic n_last;
    logic div_done;
    logic clr_last;
  } dp_stat_t;

endpackage

// ===== design/partitioned_bloom_filter_insert.sv =====
// Top level of the partitioned Bloom filter insert block.
// Instantiates pbfi_ctrl and pbfi_dp; uses pbfi_pkg.
//
// Channel   Handshake              Payload
// in_       start / busy           in_cmd, hashes, in_rep_index, in_bit_index
// out_      out_valid (no stall)   out_partition_index, out_bit_value, ...
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After reset the bit memory is cleared one bit a cycle, MAX_REPS times MAX_BITS
// rounded up to powers of two, with busy high. A read passes through S_RD and
// S_RD_OUT before its result is registered. An insert for R repetitions and H
// hashes runs each modulo step in turn through the shared bit-serial remainder unit.
// Results come out one cycle each and cannot be stalled.
module partitioned_bloom_filter_insert #(
  parameter int MAX_REPS = pbfi_pkg::MAX_REPS_DEF,
  parameter int MAX_BITS = pbfi_pkg::MAX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_cmd,
  input  logic [pbfi_pkg::HASH_W-1:0]     in_word_hash_a,
  input  logic [pbfi_pkg::HASH_W-1:0]     in_word_hash_b,
  input  logic [pbfi_pkg::HASH_W-1:0]     in_id_hash_a,
  input  logic [pbfi_pkg::HASH_W-1:0]     in_id_hash_b,
  input  logic [pbfi_pkg::REPIDX_W-1:0]   in_rep_index,
  input  logic [pbfi_pkg::BITIDX_W-1:0]   in_bit_index,
  output logic                            out_valid,
  output logic [pbfi_pkg::PART_W-1:0]     out_partition_index,
  output logic                            out_bit_value,
  output logic                            out_out_of_range,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbfi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbfi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pbfi_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pbfi_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  pbfi_dp #(.MAX_REPS(MAX_REPS), .MAX_BITS(MAX_BITS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_word_hash_a      (in_word_hash_a),
    .in_word_hash_b      (in_word_hash_b),
    .in_id_hash_a        (in_id_hash_a),
    .in_id_hash_b        (in_id_hash_b),
    .in_rep_index        (in_rep_index),
    .in_bit_index        (in_bit_index),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_partition_index (out_partition_index),
    .out_bit_value       (out_bit_value),
    .out_out_of_range    (out_out_of_range),
    .out_last            (out_last)
  );
endmodule

// ===== design/pbfi_div.sv =====
// Bit-serial remainder unit: one dividend bit per cycle, one compare and subtract.
// Depends on nothing but its parameters.
module pbfi_div #(
  parameter int DW = 64,
  parameter int MW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [MW-1:0] modulus,
  output logic          done,
  output logic [MW-1:0] rem
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [MW-1:0] mod_r, mod_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [MW:0]   sh;

  always_comb begin
    dvd_nxt  = dvd_r;
    mod_nxt  = mod_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    sh       = {rem_r, dvd_r[DW-1]};
    if (start) begin
      dvd_nxt = dividend;
      mod_nxt = modulus;
      rem_nxt = '0;
      cnt_nxt = CW'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (sh >= {1'b0, mod_r}) begin
        rem_nxt = MW'(sh - {1'b0, mod_r});
      end else begin
        rem_nxt = MW'(sh);
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    mod_r <= mod_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

// ===== design/pbfi_dp.sv =====
// Datapath: configuration registers, operand and loop registers, the bit memory
// and the output register. Uses pbfi_pkg and the remainder unit pbfi_div.
module pbfi_dp #(
  parameter int MAX_REPS = pbfi_pkg::MAX_REPS_DEF,
  parameter int MAX_BITS = pbfi_pkg::MAX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [pbfi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbfi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [pbfi_pkg::HASH_W-1:0]         in_word_hash_a,
  input  logic [pbfi_pkg::HASH_W-1:0]         in_word_hash_b,
  input  logic [pbfi_pkg::HASH_W-1:0]         in_id_hash_a,
  input  logic [pbfi_pkg::HASH_W-1:0]         in_id_hash_b,
  input  logic [pbfi_pkg::REPIDX_W-1:0]       in_rep_index,
  input  logic [pbfi_pkg::BITIDX_W-1:0]       in_bit_index,
  input  pbfi_pkg::ctl_cmd_t                  cmd,
  output pbfi_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  output logic [pbfi_pkg::PART_W-1:0]         out_partition_index,
  output logic                                out_bit_value,
  output logic                                out_out_of_range,
  output logic                                out_last
);
  import pbfi_pkg::*;

  localparam int LEN_W = $clog2(MAX_BITS + 1);
  localparam int DIV_W = (LEN_W > PART_W) ? LEN_W : PART_W;
  localparam int BI_W  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int RI_W  = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;
  localparam int AW    = RI_W + BI_W;
  localparam int DEPTH = 1 << AW;

  logic [NREP_W-1:0]  nrep_r;
  logic [NHASH_W-1:0] nhash_r;
  logic [PART_W-1:0]  npart_r;
  logic [FLEN_W-1:0]  flen_r;

  logic [NREP_W-1:0] reps;
  logic [LEN_W-1:0]  len;

  logic [HASH_W-1:0] wa_r, wb_r, ia_r, ib_r, prod_r, nb_r;
  logic [REPIDX_W-1:0] ri_r;
  logic [BITIDX_W-1:0] bi_r;
  logic [NREP_W-1:0]  rep_r;
  logic [NHASH_W-1:0] n_r;
  logic [PART_W-1:0]  rb_r, part_r;
  logic [LEN_W-1:0]   wal_r, pl_r;
  dsel_t              dsel_r;
  logic [AW-1:0]      clr_r;

  logic              div_done;
  logic [DIV_W-1:0]  div_rem;
  logic [HASH_W-1:0] div_dvd;
  logic [DIV_W-1:0]  div_mod;

  logic [PART_W:0]  psum;
  logic [PART_W-1:0] pfix;
  logic [LEN_W:0]   hsum, qsum;
  logic [LEN_W-1:0] hfix, pos;
  logic             oor;

  logic             mem [0:DEPTH-1];
  logic             we, wdata, rd_r;
  logic [AW-1:0]    waddr, raddr;

  logic                out_valid_r;
  logic [PART_W-1:0]   out_part_r;
  logic                out_bv_r, out_oor_r, out_last_r;

  assign reps = (32'(nrep_r) > MAX_REPS) ? NREP_W'(MAX_REPS) : nrep_r;
  assign len  = (32'(flen_r) > MAX_BITS) ? LEN_W'(MAX_BITS) : LEN_W'(flen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrep_r  <= NREP_RST;
      nhash_r <= NHASH_RST;
      npart_r <= NPART_RST;
      flen_r  <= FLEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_REPS:   nrep_r  <= cfg_data[NREP_W-1:0];
        REG_NUM_HASHES: nhash_r <= cfg_data[NHASH_W-1:0];
        REG_NUM_PARTS:  npart_r <= cfg_data[PART_W-1:0];
        REG_FILT_LEN:   flen_r  <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.dsel)
      DS_IB_P:   begin div_dvd = ib_r;   div_mod = DIV_W'(npart_r); end
      DS_PROD_P: begin div_dvd = prod_r; div_mod = DIV_W'(npart_r); end
      DS_WA_L:   begin div_dvd = wa_r;   div_mod = DIV_W'(len);     end
      DS_NB_L:   begin div_dvd = nb_r;   div_mod = DIV_W'(len);     end
      DS_PART_L: begin div_dvd = HASH_W'(part_r); div_mod = DIV_W'(len); end
      default:   begin div_dvd = ib_r;   div_mod = DIV_W'(npart_r); end
    endcase
  end

  pbfi_div #(.DW(HASH_W), .MW(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .modulus  (div_mod),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    psum = {1'b0, rb_r} + {1'b0, PART_W'(div_rem)};
    pfix = (psum >= {1'b0, npart_r}) ? PART_W'(psum - {1'b0, npart_r}) : PART_W'(psum);
    hsum = {1'b0, wal_r} + {1'b0, LEN_W'(div_rem)};
    hfix = (hsum >= {1'b0, len}) ? LEN_W'(hsum - {1'b0, len}) : LEN_W'(hsum);
    qsum = {1'b0, hfix} + {1'b0, pl_r};
    pos  = (qsum >= {1'b0, len}) ? LEN_W'(qsum - {1'b0, len}) : LEN_W'(qsum);
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      wa_r   <= in_word_hash_a;
      wb_r   <= in_word_hash_b;
      ia_r   <= in_id_hash_a;
      ib_r   <= in_id_hash_b;
      prod_r <= '0;
      nb_r   <= '0;
      ri_r   <= in_rep_index;
      bi_r   <= in_bit_index;
      part_r <= '0;
    end
    if (cmd.div_start) begin
      dsel_r <= cmd.dsel;
    end
    if (div_done) begin
      case (dsel_r)
        DS_IB_P:   rb_r   <= PART_W'(div_rem);
        DS_PROD_P: part_r <= pfix;
        DS_WA_L:   wal_r  <= LEN_W'(div_rem);
        DS_PART_L: pl_r   <= LEN_W'(div_rem);
        default: ;
      endcase
    end
    if (cmd.next_n) begin
      nb_r <= nb_r + wb_r;
    end
    if (cmd.next_rep) begin
      prod_r <= prod_r + ia_r;
      nb_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= '0;
      n_r   <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.init) begin
        rep_r <= '0;
        n_r   <= '0;
      end
      if (cmd.next_n) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.next_rep) begin
        rep_r <= rep_r + 1'b1;
        n_r   <= '0;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  assign oor = ({1'b0, ri_r} >= reps) || (32'(bi_r) >= 32'(len));

  always_comb begin
    we    = 1'b0;
    wdata = 1'b0;
    waddr = clr_r;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (div_done && (dsel_r == DS_NB_L)) begin
      we    = 1'b1;
      wdata = 1'b1;
      waddr = {RI_W'(rep_r), BI_W'(pos)};
    end
    raddr = {RI_W'(ri_r), BI_W'(bi_r)};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_rd || cmd.emit_ins;
    end
    if (cmd.emit_rd) begin
      out_part_r <= '0;
      out_bv_r   <= oor ? 1'b0 : rd_r;
      out_oor_r  <= oor;
      out_last_r <= 1'b1;
    end else if (cmd.emit_ins) begin
      out_part_r <= part_r;
      out_bv_r   <= 1'b0;
      out_oor_r  <= 1'b0;
      out_last_r <= stat.rep_last;
    end
  end

  assign stat.reps_zero   = (reps == '0);
  assign stat.p_zero      = (npart_r == '0);
  assign stat.len_zero    = (len == '0);
  assign stat.hashes_zero = (nhash_r == '0);
  assign stat.rep_last    = ({1'b0, rep_r} + 1'b1 == {1'b0, reps});
  assign stat.n_last      = ({1'b0, n_r} + 1'b1 == {1'b0, nhash_r});
  assign stat.div_done    = div_done;
  assign stat.clr_last    = &clr_r;

  assign out_valid           = out_valid_r;
  assign out_partition_index = out_part_r;
  assign out_bit_value       = out_bv_r;
  assign out_out_of_range    = out_oor_r;
  assign out_last            = out_last_r;
endmodule

// ===== design/pbfi_ctrl.sv =====
// Controller state machine: sequences clearing, reads and the insert loops.
// Uses pbfi_pkg; drives the datapath through ctl_cmd_t and reads dp_stat_t.
module pbfi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_cmd,
  input  pbfi_pkg::dp_stat_t  stat,
  output pbfi_pkg::ctl_cmd_t  cmd,
  output logic                busy
);
  import pbfi_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.dsel  = DS_IB_P;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.init = 1'b1;
          if (in_cmd == CMD_READ) begin
            state_nxt = S_RD;
          end else if (!stat.reps_zero) begin
            state_nxt = S_IB;
          end
        end
      end
      S_RD: state_nxt = S_RD_OUT;
      S_RD_OUT: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IB: begin
        if (stat.p_zero) begin
          state_nxt = S_WA;
        end else begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DS_IB_P;
          state_nxt     = S_IB_W;
        end
      end
      S_IB_W: if (stat.div_done) state_nxt = S_WA;
      S_WA: begin
        if (stat.len_zero) begin
          state_nxt = S_REP;
        end else begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DS_WA_L;
          state_nxt     = S_WA_W;
        end
      end
      S_WA_W: if (stat.div_done) state_nxt = S_REP;
      S_REP: begin
        if (stat.p_zero) begin
          state_nxt = S_PL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DS_PROD_P;
          state_nxt     = S_REP_W;
        end
      end
      S_REP_W: if (stat.div_done) state_nxt = S_PL;
      S_PL: begin
        if (stat.len_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DS_PART_L;
          state_nxt     = S_PL_W;
        end
      end
      S_PL_W: begin
        if (stat.div_done) begin
          state_nxt = stat.hashes_zero ? S_EMIT : S_HASH;
        end
      end
      S_HASH: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = DS_NB_L;
        state_nxt     = S_HASH_W;
      end
      S_HASH_W: begin
        if (stat.div_done) begin
          if (stat.n_last) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.next_n = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end
      S_EMIT: begin
        cmd.emit_ins = 1'b1;
        if (stat.rep_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.next_rep = 1'b1;
          state_nxt    = S_REP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== design/pbfi_checker.sv =====
// Port-level checker for the partitioned Bloom filter insert block, with its bind.
// Uses pbfi_pkg for port widths.
module pbfi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            in_cmd,
  input logic                            out_valid,
  input logic [pbfi_pkg::PART_W-1:0]     out_partition_index,
  input logic                            out_bit_value,
  input logic                            out_out_of_range,
  input logic                            out_last
);
  import pbfi_pkg::*;

  a_oor_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_last)
    else $error("out of range word without last");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> !out_bit_value && (out_partition_index == '0))
    else $error("out of range word carries data");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == CMD_READ) |=> busy)
    else $error("read accepted without going busy");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy while clearing after reset");

  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> !out_valid)
    else $error("insert words back to back");
endmodule

bind partitioned_bloom_filter_insert pbfi_checker u_pbfi_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for partitioned_bloom_filter_insert.
// Predicts partitions and stored bits in its own model of the filter and
// checks every result word; depends on pbfi_pkg and the block itself.
module testbench;
  import pbfi_pkg::*;

  typedef struct {
    logic [PART_W-1:0] partition;
    logic              bit_value;
    logic              out_of_range;
    logic              last;
  } filter_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_cmd = CMD_INSERT;
  logic [HASH_W-1:0]     in_word_hash_a = '0;
  logic [HASH_W-1:0]     in_word_hash_b = '0;
  logic [HASH_W-1:0]     in_id_hash_a = '0;
  logic [HASH_W-1:0]     in_id_hash_b = '0;
  logic [REPIDX_W-1:0]   in_rep_index = '0;
  logic [BITIDX_W-1:0]   in_bit_index = '0;
  logic                  out_valid;
  logic [PART_W-1:0]     out_partition_index;
  logic                  out_bit_value;
  logic                  out_out_of_range;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [NREP_W-1:0]  model_reps;
  logic [NHASH_W-1:0] model_hashes;
  logic [PART_W-1:0]  model_parts;
  logic [FLEN_W-1:0]  model_length;
  logic               filter_mem [MAX_REPS_DEF][MAX_BITS_DEF];
  filter_word_t       pending_words [$];
  int                 error_count = 0;
  bit                 no_idle = 1'b0;

  partitioned_bloom_filter_insert dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned reps_used();
    return (model_reps > MAX_REPS_DEF) ? MAX_REPS_DEF : model_reps;
  endfunction

  function automatic longint unsigned length_used();
    return (model_length > MAX_BITS_DEF) ? MAX_BITS_DEF : model_length;
  endfunction

  // Updates the filter model for one accepted word and queues its results.
  task automatic predict_filter(input logic cmd, input logic [HASH_W-1:0] wa, wb, ia, ib,
                                input logic [REPIDX_W-1:0] ri, input logic [BITIDX_W-1:0] bi);
    longint unsigned reps, len, p, h, pos;
    filter_word_t w;
    reps = reps_used();
    len = length_used();
    if (cmd == CMD_READ) begin
      w.partition = '0;
      w.last = 1'b1;
      w.out_of_range = (ri >= reps || bi >= len);
      w.bit_value = w.out_of_range ? 1'b0 : filter_mem[ri][bi];
      pending_words = {pending_words, w};
    end else begin
      for (longint unsigned r = 0; r < reps; r++) begin
        if (model_parts == 0) p = 0;
        else p = ((r * ia) % model_parts + ib % model_parts) % model_parts;
        if (len != 0) begin
          for (longint unsigned n = 0; n < model_hashes; n++) begin
            h = (wa % len + (n * wb) % len) % len;
            pos = (h + p) % len;
            filter_mem[r][pos] = 1'b1;
          end
        end
        w.partition = p[PART_W-1:0];
        w.bit_value = 1'b0;
        w.out_of_range = 1'b0;
        w.last = (r + 1 == reps);
        pending_words = {pending_words, w};
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got, exp_val);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, exp_val, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    filter_word_t w;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = pending_words.pop_front();
        if (out_partition_index !== w.partition)
          report_mismatch("partition_index", out_partition_index, w.partition);
        if (out_bit_value !== w.bit_value)
          report_mismatch("bit_value", out_bit_value, w.bit_value);
        if (out_out_of_range !== w.out_of_range)
          report_mismatch("out_of_range", out_out_of_range, w.out_of_range);
        if (out_last !== w.last)
          report_mismatch("last", out_last, w.last);
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [HASH_W-1:0] wa, wb, ia, ib,
                           input logic [REPIDX_W-1:0] ri, input logic [BITIDX_W-1:0] bi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_word_hash_a <= wa;
    in_word_hash_b <= wb;
    in_id_hash_a <= ia;
    in_id_hash_b <= ib;
    in_rep_index <= ri;
    in_bit_index <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_filter(cmd, wa, wb, ia, ib, ri, bi);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0 || busy) @(posedge clk);
    // An insert with no repetitions gives no word; let it finish.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NUM_REPS:   model_reps = data[NREP_W-1:0];
      REG_NUM_HASHES: model_hashes = data[NHASH_W-1:0];
      REG_NUM_PARTS:  model_parts = data[PART_W-1:0];
      REG_FILT_LEN:   model_length = data[FLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input int reps, hashes, parts, len);
    write_reg(REG_NUM_REPS, CFG_DATA_W'(reps));
    write_reg(REG_NUM_HASHES, CFG_DATA_W'(hashes));
    write_reg(REG_NUM_PARTS, CFG_DATA_W'(parts));
    write_reg(REG_FILT_LEN, CFG_DATA_W'(len));
  endtask

  function automatic logic [HASH_W-1:0] rand_hash();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic insert_word(input logic [HASH_W-1:0] wa, wb, ia, ib);
    send_word(CMD_INSERT, wa, wb, ia, ib, REPIDX_W'($urandom), BITIDX_W'($urandom));
  endtask

  task automatic read_word(input int ri, bi);
    send_word(CMD_READ, rand_hash(), rand_hash(), rand_hash(), rand_hash(),
              REPIDX_W'(ri), BITIDX_W'(bi));
  endtask

  task automatic test_reset_defaults();
    insert_word('0, '0, '0, '0);
    insert_word('1, '1, '1, '1);
    read_word(0, 0);
    read_word(0, 16383);
    read_word(3, 0);
  endtask

  task automatic test_extremes();
    set_filter(4, 255, 65535, 16384);
    insert_word('1, '1, '1, '1);
    read_word(3, 16382);
    read_word(2, 5);
    set_filter(7, 2, 0, 16'hFFFF);
    insert_word({$urandom, $urandom}, {$urandom, $urandom}, '1, '1);
    read_word(3, 100);
    read_word(1, 16383);
    set_filter(4, 0, 1, 0);
    insert_word('1, '0, '1, '0);
    read_word(0, 0);
    set_filter(0, 3, 9, 50);
    insert_word('1, '1, '1, '1);
    read_word(0, 1);
    set_filter(2, 1, 65535, 1);
    insert_word('1, '1, '1, '1);
    read_word(1, 0);
    read_word(1, 1);
  endtask

  task automatic test_random_phase(input int count);
    int reps, len;
    int ri, bi;
    reps = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    case ($urandom_range(0, 4))
      0: len = $urandom_range(0, 16);
      1: len = $urandom_range(16384, 32767);
      2: len = $urandom_range(1, 16384);
      default: len = $urandom_range(8, 200);
    endcase
    set_filter(reps, $urandom_range(0, 4),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40),
               len);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 6) begin
        insert_word(rand_hash(), rand_hash(), rand_hash(), rand_hash());
      end else begin
        ri = $urandom_range(0, 3);
        bi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                         : $urandom_range(0, 32'(length_used() + 2));
        read_word(ri, bi);
      end
      if (k == count / 2 && $urandom_range(0, 1)) drain_results();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    model_reps = NREP_RST;
    model_hashes = NHASH_RST;
    model_parts = NPART_RST;
    model_length = FLEN_RST;
    foreach (filter_mem[r, i]) filter_mem[r][i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    for (int ph = 0; ph < 6; ph++) test_random_phase(45);
    drain_results();
    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/pbfi_pkg.sv
design/pbfi_div.sv
design/pbfi_dp.sv
design/pbfi_ctrl.sv
design/partitioned_bloom_filter_insert.sv
design/pbfi_checker.sv
verif/testbench.sv
